>>> rtl/core/rle_pkg.sv
`timescale 1ns / 1ps

package rle_pkg;

  // Default literal buffer depth and run limit
  localparam int LIT_MAX_DEF = 63;
  localparam int RUN_MAX_DEF = 129;

  // Input commands
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Literal token header is base + count
  localparam logic [7:0] LIT_HDR_BASE = 8'd128;

endpackage

>>> rtl/core/rle_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write port, one registered read port.
// Read data holds while rd_en is low.
module rle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 63,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/rle_byte_encoder.sv
`timescale 1ns / 1ps

// Channel   Valid         Stall         Payload
// input     byte_valid    byte_stall    command, data_byte
// output    token_valid   token_stall   out_byte, last
//
// An input word is taken while the sequencer is idle; a word
// that emits nothing leaves the block ready again on the next cycle.
// A word that emits output words keeps the input stalled until its last
// word is loaded; output words leave one per cycle while token_stall is low,
// literal payload streamed from the RAM.
// Reset (rst, synchronous) empties the literal buffer and closes any run.
// The output register keeps its word through token_stall; the sequencer
// waits on it and the input stays stalled until the last word is loaded.
module rle_byte_encoder #(
  parameter int LIT_MAX = rle_pkg::LIT_MAX_DEF,
  parameter int RUN_MAX = rle_pkg::RUN_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic       command,
  input  logic [7:0] data_byte,
  output logic       token_valid,
  input  logic       token_stall,
  output logic [7:0] out_byte,
  output logic       last
);

  // Address width of the literal store, width of a literal count 0..LIT_MAX
  localparam int AW = $clog2(LIT_MAX);
  localparam int KW = $clog2(LIT_MAX + 1);

  localparam logic [KW-1:0] LIT_FULL = KW'(LIT_MAX);
  localparam logic [7:0]    RUN_LIM  = 8'(RUN_MAX);
  // A fresh run of two already hits the limit
  localparam logic          RUN_TWO_CLOSES = (RUN_MAX <= 2);

  // Sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_LIT_HDR  = 3'd1;
  localparam logic [2:0] S_LIT_BYTE = 3'd2;
  localparam logic [2:0] S_RUN_HDR  = 3'd3;
  localparam logic [2:0] S_RUN_VAL  = 3'd4;

  logic [2:0]    state, state_next;

  // Encoder state
  logic [AW-1:0] lit_count, lit_count_next;
  logic          run_active, run_active_next;
  logic [7:0]    run_value, run_value_next;
  logic [7:0]    run_length, run_length_next;
  logic [7:0]    last_byte, last_byte_next;   // copy of newest buffered byte

  // Emit plan for the current word
  logic [KW-1:0] lit_k, lit_k_next;           // literal bytes to flush
  logic          run_pend, run_pend_next;     // run token follows
  logic [7:0]    run_hdr, run_hdr_next;
  logic [7:0]    run_val, run_val_next;
  logic [AW-1:0] idx, idx_next;               // index of byte in rd_data

  // Literal store ports
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  logic          accept;
  logic          out_free;
  logic          load;
  logic [7:0]    load_byte;
  logic          load_last;
  logic [7:0]    len_inc;
  logic          lit_last;

  assign byte_stall = (state != S_IDLE);
  assign accept     = byte_valid && (state == S_IDLE);
  assign out_free   = !token_valid || !token_stall;
  assign len_inc    = run_length + 8'd1;
  assign lit_last   = ((KW'(idx) + KW'(1)) == lit_k);

  rle_ram #(
    .WIDTH (8),
    .DEPTH (LIT_MAX)
  ) u_lit_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (data_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Word decode: new encoder state, store write and emit plan
  always_comb begin
    lit_count_next  = lit_count;
    run_active_next = run_active;
    run_value_next  = run_value;
    run_length_next = run_length;
    last_byte_next  = last_byte;
    lit_k_next      = lit_k;
    run_pend_next   = run_pend;
    run_hdr_next    = run_hdr;
    run_val_next    = run_val;
    wr_en           = 1'b0;
    wr_addr         = lit_count;

    if (accept) begin
      lit_k_next    = '0;
      run_pend_next = 1'b0;
      run_hdr_next  = run_length - 8'd1;
      run_val_next  = run_value;
      if (command == rle_pkg::CMD_END) begin
        if (run_active) begin
          run_pend_next   = 1'b1;
          run_active_next = 1'b0;
          run_length_next = '0;
        end else begin
          lit_k_next = KW'(lit_count);
        end
        lit_count_next = '0;
      end else if (run_active) begin
        if (data_byte == run_value) begin
          run_length_next = len_inc;
          if (len_inc >= RUN_LIM) begin
            run_pend_next   = 1'b1;
            run_hdr_next    = run_length;
            run_active_next = 1'b0;
            run_length_next = '0;
          end
        end else begin
          // close the run, the new byte opens a literal buffer
          run_pend_next   = 1'b1;
          run_active_next = 1'b0;
          run_length_next = '0;
          wr_en           = 1'b1;
          wr_addr         = '0;
          lit_count_next  = AW'(1);
          last_byte_next  = data_byte;
        end
      end else if ((lit_count != '0) && (data_byte == last_byte)) begin
        // byte repeats the newest literal: flush the rest, open a run of two
        if (lit_count != AW'(1)) begin
          lit_k_next = KW'(lit_count) - KW'(1);
        end
        lit_count_next  = '0;
        run_active_next = 1'b1;
        run_value_next  = data_byte;
        run_length_next = 8'd2;
        if (RUN_TWO_CLOSES) begin
          run_pend_next   = 1'b1;
          run_hdr_next    = 8'd1;
          run_val_next    = data_byte;
          run_active_next = 1'b0;
          run_length_next = '0;
        end
      end else begin
        wr_en          = 1'b1;
        last_byte_next = data_byte;
        if ((KW'(lit_count) + KW'(1)) == LIT_FULL) begin
          lit_k_next     = LIT_FULL;
          lit_count_next = '0;
        end else begin
          lit_count_next = lit_count + AW'(1);
        end
      end
    end
  end

  // Emit sequencer
  always_comb begin
    state_next = state;
    idx_next   = idx;
    rd_en      = 1'b0;
    rd_addr    = idx + AW'(1);
    load       = 1'b0;
    load_byte  = rd_data;
    load_last  = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (lit_k_next != '0) begin
            state_next = S_LIT_HDR;
          end else if (run_pend_next) begin
            state_next = S_RUN_HDR;
          end
        end
      end
      S_LIT_HDR: begin
        if (out_free) begin
          load       = 1'b1;
          load_byte  = rle_pkg::LIT_HDR_BASE + 8'(lit_k);
          rd_en      = 1'b1;
          rd_addr    = '0;
          idx_next   = '0;
          state_next = S_LIT_BYTE;
        end
      end
      S_LIT_BYTE: begin
        if (out_free) begin
          load      = 1'b1;
          load_byte = rd_data;
          load_last = lit_last && !run_pend;
          if (lit_last) begin
            state_next = run_pend ? S_RUN_HDR : S_IDLE;
          end else begin
            // fetch the next byte as this one leaves
            rd_en    = 1'b1;
            idx_next = idx + AW'(1);
          end
        end
      end
      S_RUN_HDR: begin
        if (out_free) begin
          load       = 1'b1;
          load_byte  = run_hdr;
          state_next = S_RUN_VAL;
        end
      end
      S_RUN_VAL: begin
        if (out_free) begin
          load       = 1'b1;
          load_byte  = run_val;
          load_last  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      lit_count   <= '0;
      run_active  <= 1'b0;
      run_value   <= '0;
      run_length  <= '0;
      token_valid <= 1'b0;
    end else begin
      state      <= state_next;
      lit_count  <= lit_count_next;
      run_active <= run_active_next;
      run_value  <= run_value_next;
      run_length <= run_length_next;
      if (load) begin
        token_valid <= 1'b1;
      end else if (!token_stall) begin
        token_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    last_byte <= last_byte_next;
    lit_k     <= lit_k_next;
    run_pend  <= run_pend_next;
    run_hdr   <= run_hdr_next;
    run_val   <= run_val_next;
    idx       <= idx_next;
    if (load) begin
      out_byte <= load_byte;
      last     <= load_last;
    end
  end

  // Buffer never holds a full LIT_MAX between words
  a_lit_count_range: assert property (@(posedge clk) disable iff (rst)
    KW'(lit_count) < LIT_FULL)
    else $error("literal count reached buffer depth");

  // An open run leaves the literal buffer empty
  a_run_no_lit: assert property (@(posedge clk) disable iff (rst)
    run_active |-> (lit_count == '0))
    else $error("run open with buffered literals");

  // An open run is between two bytes and one short of the limit
  a_run_len: assert property (@(posedge clk) disable iff (rst)
    run_active |-> ((run_length >= 8'd2) && (run_length < RUN_LIM)))
    else $error("run length out of range");

  // Literal streaming stays inside the flush count
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIT_BYTE) |-> ((KW'(idx) < lit_k) && (lit_k != '0)))
    else $error("literal index beyond flush count");

  // Last word of a word's output returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (load && load_last) |=> (state == S_IDLE))
    else $error("last word loaded but sequencer busy");

endmodule
